// ===== design/edsg_pkg.sv =====
// ----------------------------------------------------------------------------
// edsg_pkg: shared types and constants for the envelope decay/smooth/gate core
// Holds the field widths, the gate constants and the request/response structs
// that connect the sequencer to the serial divider.
// ----------------------------------------------------------------------------
package edsg_pkg;

    localparam int LevelW   = 16;
    localparam int CountW   = 17;
    localparam int DivW     = 16;
    localparam int DividW   = 24;
    localparam int DivSteps = DividW;
    localparam int StepW    = $clog2(DivSteps);

    localparam logic [1:0] CfgMode      = 2'd0;
    localparam logic [1:0] CfgStrength  = 2'd1;
    localparam logic [1:0] CfgThreshold = 2'd2;
    localparam logic [1:0] CfgHoldLen   = 2'd3;

    localparam logic [1:0] ModeDecay = 2'd0;

    localparam logic signed [LevelW-1:0] GateOnLevel = 16'sd4096;
    localparam logic [CountW-1:0]        CountMax    = 17'h1FFFF;
    localparam logic [DivW-1:0]          StrengthOne = 16'd256;

    typedef struct packed {
        logic              start;
        logic              negative;
        logic [DividW-1:0] dividend;
        logic [DivW-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                      done;
        logic signed [CountW-1:0]  quotient;
    } t_div_rsp;

endpackage

// ===== design/edsg_divider.sv =====
// ----------------------------------------------------------------------------
// edsg_divider: serial restoring divider
// Divides an unsigned magnitude by an unsigned divisor one quotient bit per
// cycle and applies the sign at the end, which truncates toward zero.
// ----------------------------------------------------------------------------
module edsg_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  edsg_pkg::t_div_req i_req,
    output edsg_pkg::t_div_rsp o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [edsg_pkg::StepW-1:0]  r_count;
    logic [edsg_pkg::DividW-1:0] r_quo;
    logic [edsg_pkg::DivW-1:0]   r_rem;
    logic [edsg_pkg::DivW-1:0]   r_div;
    logic                        r_neg;

    logic [edsg_pkg::DivW:0]     rem_sh;
    logic                        fits;
    logic [edsg_pkg::DivW:0]     rem_nx;
    logic signed [edsg_pkg::CountW-1:0] mag;

    always_comb begin
        rem_sh = {r_rem, r_quo[edsg_pkg::DividW-1]};
        fits   = rem_sh >= {1'b0, r_div};
        rem_nx = fits ? (rem_sh - {1'b0, r_div}) : rem_sh;
        // The quotient never exceeds the 16-bit difference, so 17 bits hold it.
        mag    = r_quo[edsg_pkg::CountW-1:0];
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? -mag : mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + 1'b1;
                if (r_count == edsg_pkg::StepW'(edsg_pkg::DivSteps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_neg <= i_req.negative;
        end else if (r_busy) begin
            r_quo <= {r_quo[edsg_pkg::DividW-2:0], fits};
            r_rem <= rem_nx[edsg_pkg::DivW-1:0];
        end
    end

endmodule

// ===== design/envelope_decay_smooth_gate_core.sv =====
// ----------------------------------------------------------------------------
// envelope_decay_smooth_gate_core: level follower with decay, smoothing, gate
// Conditions one signed Q3.12 level per transfer into one conditioned level.
// ----------------------------------------------------------------------------
// Usage notes.
// The input channel carries i_level_in and i_start_of_run; a transfer happens
// when i_in_valid is high and o_in_stall is low. The output channel carries
// o_level_out; a transfer happens when o_out_valid is high and i_out_stall is
// low. Every input transfer produces exactly one output transfer.
// The block works on one item at a time. Gate mode and the upward jump of
// decay mode decide the new level in the accept cycle and go straight to
// the output state; the steps that move toward the input divide the scaled
// difference by strength in a serial divider that yields one quotient bit
// per cycle. In every mode no new input is taken until the result has been
// written to the output register.
// The output sits in a register, so the next item is accepted while a result
// waits; a stalled receiver only holds the block once a second result is
// ready to be written over the waiting one.
// Configuration writes through i_cfg_we/i_cfg_index/i_cfg_data land at once
// and are expected only while the block is idle.
// Reset (synchronous, active low) restores the register defaults, clears the
// follower state and empties the output register.
// ----------------------------------------------------------------------------
module envelope_decay_smooth_gate_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [15:0]                        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [edsg_pkg::LevelW-1:0] i_level_in,
    input  logic                               i_start_of_run,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [edsg_pkg::LevelW-1:0] o_level_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] r_state;

    // Configuration registers.
    logic [1:0]                         r_mode;
    logic [edsg_pkg::DivW-1:0]          r_strength;
    logic signed [edsg_pkg::LevelW-1:0] r_threshold;
    logic [15:0]                        r_hold_len;

    // Follower state shared by all modes.
    logic signed [edsg_pkg::LevelW-1:0] r_held;
    logic [edsg_pkg::CountW-1:0]        r_cnt;
    logic                               r_cleared;

    logic                               r_out_valid;
    logic signed [edsg_pkg::LevelW-1:0] r_out_level;

    logic                               in_xfer;
    logic                               out_free;
    logic signed [edsg_pkg::LevelW-1:0] eff_held;
    logic [edsg_pkg::CountW-1:0]        eff_cnt;
    logic                               eff_cleared;
    logic [edsg_pkg::CountW-1:0]        cnt_inc;
    logic signed [edsg_pkg::LevelW:0]   diff;
    logic [edsg_pkg::LevelW-1:0]        diff_mag;
    logic signed [edsg_pkg::LevelW:0]   step_sum;

    logic signed [edsg_pkg::LevelW-1:0] n_held;
    logic [edsg_pkg::CountW-1:0]        n_cnt;
    logic                               n_cleared;
    logic                               n_need_div;

    edsg_pkg::t_div_req div_req;
    edsg_pkg::t_div_rsp div_rsp;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_level_out = r_out_level;

    // A start-of-run item sees cleared state before anything else happens.
    always_comb begin
        eff_held    = i_start_of_run ? '0 : r_held;
        eff_cnt     = i_start_of_run ? '0 : r_cnt;
        eff_cleared = i_start_of_run ? 1'b0 : r_cleared;
        cnt_inc     = (eff_cnt < edsg_pkg::CountMax) ? eff_cnt + 1'b1 : eff_cnt;
        diff        = {i_level_in[edsg_pkg::LevelW-1], i_level_in}
                    - {eff_held[edsg_pkg::LevelW-1], eff_held};
        diff_mag    = diff[edsg_pkg::LevelW] ? edsg_pkg::LevelW'(-diff)
                                             : diff[edsg_pkg::LevelW-1:0];
        step_sum    = {r_held[edsg_pkg::LevelW-1], r_held} + div_rsp.quotient;
    end

    // Decide the update in the accept cycle; only the divided step waits.
    always_comb begin
        n_held     = eff_held;
        n_cnt      = eff_cnt;
        n_cleared  = eff_cleared;
        n_need_div = 1'b0;
        if (r_mode[1]) begin
            n_cnt = cnt_inc;
            if (i_level_in > r_threshold) begin
                if (!eff_cleared) begin
                    n_cnt     = '0;
                    n_cleared = 1'b1;
                end
                n_held = edsg_pkg::GateOnLevel;
            end else if (cnt_inc > {1'b0, r_hold_len}) begin
                n_held    = '0;
                n_cnt     = '0;
                n_cleared = 1'b0;
            end
        end else if (r_mode == edsg_pkg::ModeDecay && i_level_in > eff_held) begin
            n_held = i_level_in;
        end else begin
            n_need_div = 1'b1;
        end
    end

    // Strength below 1.0 is clamped to 1.0 before the divide.
    always_comb begin
        div_req.start    = in_xfer && n_need_div;
        div_req.negative = diff[edsg_pkg::LevelW];
        div_req.dividend = {diff_mag, 8'd0};
        div_req.divisor  = (r_strength < edsg_pkg::StrengthOne) ? edsg_pkg::StrengthOne
                                                                : r_strength;
    end

    edsg_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= edsg_pkg::ModeDecay;
            r_strength  <= edsg_pkg::StrengthOne;
            r_threshold <= 16'sd2048;
            r_hold_len  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                edsg_pkg::CfgMode:      r_mode      <= i_cfg_data[1:0];
                edsg_pkg::CfgStrength:  r_strength  <= i_cfg_data;
                edsg_pkg::CfgThreshold: r_threshold <= i_cfg_data;
                edsg_pkg::CfgHoldLen:   r_hold_len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_held      <= '0;
            r_cnt       <= '0;
            r_cleared   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result takes the output register as the old one leaves.
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_held    <= n_held;
                        r_cnt     <= n_cnt;
                        r_cleared <= n_cleared;
                        r_state   <= n_need_div ? ST_DIV : ST_OUT;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_held  <= step_sum[edsg_pkg::LevelW-1:0];
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_out_level <= r_held;
        end
    end

    // The divider only answers while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == ST_DIV)
        else $error("divider finished outside the divide state");

    // Gate items never use the divider.
    a_gate_no_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_mode[1]) |=> r_state == ST_OUT)
        else $error("gate item did not go straight to output");

    // A result written to the output register carries the follower value.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free) |=> (o_out_valid && o_level_out == $past(r_held)))
        else $error("output register not loaded with follower value");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the envelope decay/smooth/gate core
// Drives level samples through the valid/stall input channel, predicts every
// conditioned level with a cycle-free model of the follower and compares
// each output transfer with the oldest owed level. A directed table opens
// the run, and random settings and sequences follow.
// ----------------------------------------------------------------------------
module tb_top;

    // Mode codes beyond the one the package names. Bit 1 selects the gate,
    // so code 3 is a second spelling of the gate.
    localparam logic [1:0] ModeSmooth    = 2'd1;
    localparam logic [1:0] ModeGate      = 2'd2;
    localparam logic [1:0] ModeGateAlias = 2'd3;

    // The slowest item is one that goes through the serial divide.
    localparam int SettleCycles  = 30;
    localparam int HoldoffCycles = 300;

    logic                               i_clk          = 1'b0;
    logic                               i_rst_n        = 1'b0;
    logic                               i_cfg_we       = 1'b0;
    logic [1:0]                         i_cfg_index    = edsg_pkg::CfgMode;
    logic [15:0]                        i_cfg_data     = '0;
    logic                               i_in_valid     = 1'b0;
    logic                               o_in_stall;
    logic signed [edsg_pkg::LevelW-1:0] i_level_in     = '0;
    logic                               i_start_of_run = 1'b0;
    logic                               o_out_valid;
    logic                               i_out_stall    = 1'b0;
    logic signed [edsg_pkg::LevelW-1:0] o_level_out;

    envelope_decay_smooth_gate_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_level_in     (i_level_in),
        .i_start_of_run (i_start_of_run),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_level_out    (o_level_out)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Follower prediction. The bench keeps its own copy of the registers and
    // of the follower state; both start from the reset values.
    // ------------------------------------------------------------------------
    logic [1:0]                         cfg_mode      = edsg_pkg::ModeDecay;
    logic [15:0]                        cfg_strength  = edsg_pkg::StrengthOne;
    logic signed [edsg_pkg::LevelW-1:0] cfg_threshold = 16'sd2048;
    logic [15:0]                        cfg_hold      = '0;

    logic signed [edsg_pkg::LevelW-1:0] env_level  = '0;
    logic [edsg_pkg::CountW-1:0]        gate_count = '0;
    logic                               gate_armed = 1'b0;

    // Conditioned levels still owed by the block, oldest first.
    logic signed [edsg_pkg::LevelW-1:0] level_expect_q [$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int fail_count     = 0;
    int holdoff_ticket = 0;

    // Advances the follower by one sample and returns the level it now holds.
    function automatic logic signed [edsg_pkg::LevelW-1:0] follow_level(
        input logic signed [edsg_pkg::LevelW-1:0] level,
        input logic                               restart
    );
        int diff;
        int divisor;
        if (restart) begin
            env_level  = '0;
            gate_count = '0;
            gate_armed = 1'b0;
        end
        if (cfg_mode[1]) begin
            // The gate counts every item, saturating at the top of the range.
            if (gate_count != edsg_pkg::CountMax)
                gate_count = gate_count + 1'b1;
            if (level > cfg_threshold) begin
                // Only the first item of an on-period restarts the count.
                if (!gate_armed) begin
                    gate_count = '0;
                    gate_armed = 1'b1;
                end
                env_level = edsg_pkg::GateOnLevel;
            end else if (gate_count > {1'b0, cfg_hold}) begin
                env_level  = '0;
                gate_count = '0;
                gate_armed = 1'b0;
            end
        end else if (cfg_mode == edsg_pkg::ModeDecay && level > env_level) begin
            // The peak follower jumps straight up to a higher sample.
            env_level = level;
        end else begin
            // Move toward the sample by the difference over strength, with a
            // strength below 1.0 taken as 1.0; division truncates toward zero.
            diff      = int'(level) - int'(env_level);
            divisor   = (cfg_strength < edsg_pkg::StrengthOne)
                      ? int'(edsg_pkg::StrengthOne) : int'(cfg_strength);
            env_level = edsg_pkg::LevelW'(int'(env_level) + (diff * 256) / divisor);
        end
        return env_level;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers. Every task is entered right after a rising edge, so
    // all drives land as nonblocking assignments at that edge.
    // ------------------------------------------------------------------------

    // Offers one sample and holds it until the block takes it. A typed-in
    // expectation replaces the prediction for rows that carry one; the
    // follower state still advances so that later rows stay in step.
    task automatic offer_level(
        input logic signed [edsg_pkg::LevelW-1:0] level,
        input logic                               restart,
        input logic                               known,
        input logic signed [edsg_pkg::LevelW-1:0] want
    );
        logic signed [edsg_pkg::LevelW-1:0] predicted;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_level_in     <= level;
        i_start_of_run <= restart;
        do @(posedge i_clk); while (o_in_stall);
        predicted = follow_level(level, restart);
        level_expect_q.insert(level_expect_q.size(), known ? want : predicted);
    endtask

    // Stops offering and waits until every owed level has come out, then
    // lets the given number of cycles pass so the block is surely idle.
    task automatic wait_idle(input int extra);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (level_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // One register write, held for a single edge. The predictor's copy of
    // the register follows the same masking the block applies.
    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (index)
            edsg_pkg::CfgMode:      cfg_mode      = data[1:0];
            edsg_pkg::CfgStrength:  cfg_strength  = data;
            edsg_pkg::CfgThreshold: cfg_threshold = data;
            edsg_pkg::CfgHoldLen:   cfg_hold      = data;
            default:                ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Directed table. A row either writes a register (after the block has
    // gone idle) or offers one sample. Expected levels are typed in where
    // they follow directly from the rules; the rest come from the predictor.
    // ------------------------------------------------------------------------
    typedef enum logic {RowItem, RowReg} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [1:0]         reg_index;
        logic [15:0]        value;
        logic               restart;
        logic               known;
        logic signed [15:0] want;
    } t_stim_row;

    t_stim_row directed_rows [35] = '{
        // Peak decay at strength 1.0: jump to the top, then fall all the way.
        '{RowItem, edsg_pkg::CfgMode,      16'h7FFF, 1'b1, 1'b1, 16'sh7FFF},
        '{RowItem, edsg_pkg::CfgMode,      16'h8000, 1'b0, 1'b1, 16'sh8000},
        '{RowItem, edsg_pkg::CfgMode,      16'h0064, 1'b1, 1'b1, 16'sd100},
        // A zero strength acts as 1.0, so the step is the whole difference.
        '{RowReg,  edsg_pkg::CfgStrength,  16'h0000, 1'b0, 1'b0, 16'sd0},
        '{RowItem, edsg_pkg::CfgMode,      16'hFF38, 1'b0, 1'b1, -16'sd200},
        // Largest strength: the slowest decay from the top of the range.
        '{RowReg,  edsg_pkg::CfgStrength,  16'hFFFF, 1'b0, 1'b0, 16'sd0},
        '{RowItem, edsg_pkg::CfgMode,      16'h7FFF, 1'b0, 1'b1, 16'sh7FFF},
        '{RowItem, edsg_pkg::CfgMode,      16'h8000, 1'b0, 1'b0, 16'sd0},
        '{RowItem, edsg_pkg::CfgMode,      16'h8000, 1'b0, 1'b0, 16'sd0},
        // One-pole smoothing at strength 2.0 halves the distance each item.
        '{RowReg,  edsg_pkg::CfgMode,      16'(ModeSmooth), 1'b0, 1'b0, 16'sd0},
        '{RowReg,  edsg_pkg::CfgStrength,  16'h0200, 1'b0, 1'b0, 16'sd0},
        '{RowItem, edsg_pkg::CfgMode,      16'h03E8, 1'b1, 1'b1, 16'sd500},
        '{RowItem, edsg_pkg::CfgMode,      16'h03E8, 1'b0, 1'b0, 16'sd0},
        '{RowItem, edsg_pkg::CfgMode,      16'h8000, 1'b0, 1'b0, 16'sd0},
        // Gate with a hold of two: on above threshold, equal does not count,
        // and the output drops once the count passes the hold length.
        '{RowReg,  edsg_pkg::CfgMode,      16'(ModeGate), 1'b0, 1'b0, 16'sd0},
        '{RowReg,  edsg_pkg::CfgThreshold, 16'h0800, 1'b0, 1'b0, 16'sd0},
        '{RowReg,  edsg_pkg::CfgHoldLen,   16'h0002, 1'b0, 1'b0, 16'sd0},
        '{RowItem, edsg_pkg::CfgMode,      16'h0801, 1'b1, 1'b1, edsg_pkg::GateOnLevel},
        '{RowItem, edsg_pkg::CfgMode,      16'h0800, 1'b0, 1'b1, edsg_pkg::GateOnLevel},
        '{RowItem, edsg_pkg::CfgMode,      16'h0000, 1'b0, 1'b1, edsg_pkg::GateOnLevel},
        '{RowItem, edsg_pkg::CfgMode,      16'h0000, 1'b0, 1'b1, 16'sd0},
        // Threshold at both ends of the range, no hold.
        '{RowReg,  edsg_pkg::CfgThreshold, 16'h8000, 1'b0, 1'b0, 16'sd0},
        '{RowReg,  edsg_pkg::CfgHoldLen,   16'h0000, 1'b0, 1'b0, 16'sd0},
        '{RowItem, edsg_pkg::CfgMode,      16'h8000, 1'b1, 1'b1, 16'sd0},
        '{RowItem, edsg_pkg::CfgMode,      16'h7FFF, 1'b0, 1'b1, edsg_pkg::GateOnLevel},
        '{RowReg,  edsg_pkg::CfgThreshold, 16'h7FFF, 1'b0, 1'b0, 16'sd0},
        '{RowItem, edsg_pkg::CfgMode,      16'h7FFF, 1'b0, 1'b1, 16'sd0},
        // The unused mode code behaves as the gate.
        '{RowReg,  edsg_pkg::CfgMode,      16'(ModeGateAlias), 1'b0, 1'b0, 16'sd0},
        '{RowReg,  edsg_pkg::CfgThreshold, 16'h0000, 1'b0, 1'b0, 16'sd0},
        '{RowItem, edsg_pkg::CfgMode,      16'h0001, 1'b0, 1'b1, edsg_pkg::GateOnLevel},
        '{RowItem, edsg_pkg::CfgMode,      16'h0000, 1'b0, 1'b1, 16'sd0},
        // Back to peak decay without a start: the shared state carries over.
        // A strength just under 1.0 is still taken as 1.0.
        '{RowReg,  edsg_pkg::CfgMode,      16'(edsg_pkg::ModeDecay), 1'b0, 1'b0, 16'sd0},
        '{RowReg,  edsg_pkg::CfgStrength,  16'h00FF, 1'b0, 1'b0, 16'sd0},
        '{RowItem, edsg_pkg::CfgMode,      16'h8000, 1'b0, 1'b1, 16'sh8000},
        '{RowItem, edsg_pkg::CfgMode,      16'h7FFF, 1'b0, 1'b1, 16'sh7FFF}
    };

    // ------------------------------------------------------------------------
    // Receiver. Stalls at random, and on request holds off for a long stretch
    // so that the block fills up and pushes back on the sender. A request is
    // a change of the ticket; only this process writes the stall.
    // ------------------------------------------------------------------------
    int holdoff_seen = 0;
    int holdoff_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall  <= 1'b0;
            holdoff_seen <= 0;
            holdoff_left <= 0;
        end else if (holdoff_seen != holdoff_ticket) begin
            holdoff_seen <= holdoff_ticket;
            holdoff_left <= HoldoffCycles;
            i_out_stall  <= 1'b1;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            i_out_stall  <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result check. Each output transfer is matched against the oldest owed
    // level; a transfer with nothing owed is a failure of its own.
    // ------------------------------------------------------------------------
    logic signed [edsg_pkg::LevelW-1:0] owed_level;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (level_expect_q.size() == 0) begin
                $display("%0t: unexpected level_out transfer, got %0d",
                         $time, o_level_out);
                fail_count = fail_count + 1;
            end else begin
                owed_level = level_expect_q.pop_front();
                if (o_level_out !== owed_level) begin
                    $display("%0t: level_out mismatch, expected %0d, got %0d",
                             $time, owed_level, o_level_out);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : run_sequence
        int                                 phase;
        int                                 n;
        int                                 items;
        int                                 pick;
        int                                 near;
        logic signed [edsg_pkg::LevelW-1:0] level;
        logic signed [edsg_pkg::LevelW-1:0] last_level;
        logic                               restart;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // The directed part runs under the first idling pattern.
        send_idle_pct = 11;
        recv_idle_pct = 51;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == RowReg) begin
                wait_idle(SettleCycles);
                write_reg(directed_rows[r].reg_index, directed_rows[r].value);
            end else begin
                offer_level(directed_rows[r].value, directed_rows[r].restart,
                            directed_rows[r].known, directed_rows[r].want);
            end
        end

        // Random phases. Each one programs a fresh setting while the block is
        // idle and then runs a sequence that normally opens with a start; a
        // few sequences skip the start and carry the old state in. Phases 0-3
        // idle the sender lightly and the receiver heavily, 4-7 the reverse,
        // and 8-11 do not idle at all.
        last_level = '0;
        for (phase = 0; phase < 12; phase++) begin
            wait_idle(SettleCycles);
            send_idle_pct = (phase < 4) ? 11 : (phase < 8) ? 51 : 0;
            recv_idle_pct = (phase < 4) ? 51 : (phase < 8) ? 11 : 0;

            write_reg(edsg_pkg::CfgMode, 16'($urandom));

            pick = $urandom_range(7);
            case (pick)
                0:       write_reg(edsg_pkg::CfgStrength, 16'($urandom_range(255)));
                1:       write_reg(edsg_pkg::CfgStrength, 16'hFFFF);
                2:       write_reg(edsg_pkg::CfgStrength, edsg_pkg::StrengthOne);
                3:       write_reg(edsg_pkg::CfgStrength, 16'($urandom));
                default: write_reg(edsg_pkg::CfgStrength,
                                   16'($urandom_range(4096, 257)));
            endcase

            pick = $urandom_range(5);
            case (pick)
                0:       write_reg(edsg_pkg::CfgThreshold, 16'h8000);
                1:       write_reg(edsg_pkg::CfgThreshold, 16'h7FFF);
                2:       write_reg(edsg_pkg::CfgThreshold, 16'($urandom));
                default: write_reg(edsg_pkg::CfgThreshold,
                                   16'(int'($urandom_range(16384)) - 8192));
            endcase

            // Short holds keep the gate switching; long ones test the count.
            pick = $urandom_range(5);
            case (pick)
                0:       write_reg(edsg_pkg::CfgHoldLen, 16'hFFFF);
                1:       write_reg(edsg_pkg::CfgHoldLen, 16'($urandom));
                default: write_reg(edsg_pkg::CfgHoldLen, 16'($urandom_range(6)));
            endcase

            items = $urandom_range(100, 80);
            for (n = 0; n < items; n++) begin
                // Long receiver hold-off while the sender keeps offering.
                if ((phase == 1 || phase == 9) && n == 10)
                    holdoff_ticket <= holdoff_ticket + 1;
                // Sender pause until every owed level has come out.
                if (phase == 5 && n == 40)
                    wait_idle(0);

                pick = $urandom_range(99);
                if (pick < 8) begin
                    level = 16'sh7FFF;
                end else if (pick < 16) begin
                    level = 16'sh8000;
                end else if (pick < 65) begin
                    // Near the threshold for the gate, near the last sample
                    // otherwise, so the followers settle in small steps.
                    near = cfg_mode[1] ? int'(cfg_threshold) : int'(last_level);
                    near = near + int'($urandom_range(600)) - 300;
                    if (near > 32767)
                        near = 32767;
                    if (near < -32768)
                        near = -32768;
                    level = edsg_pkg::LevelW'(near);
                end else begin
                    level = edsg_pkg::LevelW'($urandom);
                end
                last_level = level;

                if (n == 0)
                    restart = ($urandom_range(5) != 0);
                else
                    restart = ($urandom_range(39) == 0);
                offer_level(level, restart, 1'b0, '0);
            end
        end

        wait_idle(SettleCycles);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/edsg_pkg.sv
design/edsg_divider.sv
design/envelope_decay_smooth_gate_core.sv
tb/tb_top.sv
